### hw/rtl/slm_pkg.sv
// ---------------------------------------------------------------------------
// slm_pkg
// Shared types and constants of the sequence/acknowledge liveness monitor.
// ---------------------------------------------------------------------------
package slm_pkg;

  // input item codes
  typedef enum logic {
    OpTick = 1'b0,
    OpByte = 1'b1
  } slm_op_e;

  // result item codes
  typedef enum logic {
    KindProbe  = 1'b0,
    KindHeader = 1'b1
  } slm_kind_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSessionId    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLossThreshold = 2'd1;

  localparam logic [15:0] SessionIdReset     = 16'd1;
  localparam logic [15:0] LossThresholdReset = 16'd3;

  // probe tlv and offset limits
  localparam logic [7:0]  TlvTypeProbe = 8'd142;
  localparam logic [7:0]  TlvLenProbe  = 8'd14;
  localparam logic [11:0] OffsetMax    = 12'hFFF;

  // classified event from the header parser to the link engine
  typedef struct packed {
    slm_kind_e   kind;
    logic        matched;
    logic        ack_zero;
    logic [15:0] seq;
  } slm_evt_t;

  // result transaction
  typedef struct packed {
    slm_kind_e   kind;
    logic [15:0] probe_seq;
    logic [15:0] probe_ack;
    logic        link_is_up;
    logic        link_changed;
    logic        probe_matched;
  } slm_res_t;

endpackage

### hw/rtl/slm_fifo.sv
// ---------------------------------------------------------------------------
// slm_fifo
// Small register queue with combinational read of the oldest entry.
// ---------------------------------------------------------------------------
module slm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] regs_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = regs_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      regs_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/slm_front.sv
// ---------------------------------------------------------------------------
// slm_front
// Header byte parser: walks the tlv list and classifies each tick and each last
// header byte into a tick or end-of-header event for the link engine.
// ---------------------------------------------------------------------------
module slm_front import slm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] session_id_i,
  output logic        evt_push_o,
  output slm_evt_t    evt_o
);

  logic [11:0] off_q, off_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [11:0] next_q, next_d;
  logic [7:0]  tkind_q, tkind_d;
  logic [11:0] base_q, base_d;
  logic        sel_q, sel_d;
  logic [15:0] ses_q, ses_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] ack_q, ack_d;

  logic        is_byte;
  logic [11:0] end_bound;
  logic [12:0] start;
  logic [12:0] next_p1;
  logic [12:0] next_step;
  logic        walk_en;
  logic [11:0] rel;
  logic        cap_en;
  logic [12:0] tail;
  logic        matched;

  assign is_byte = accept_i && (slm_op_e'(opcode_i) == OpByte);

  // offsets used by the walk
  assign end_bound = {({1'b0, hlen_q} + 9'd1), 3'b000};
  assign start     = {({1'b0, data_byte_i} + 9'd1), 4'b0000} + 13'd8;
  assign next_p1   = {1'b0, next_q} + 13'd1;
  assign next_step = {1'b0, next_q} + 13'd2 + {5'd0, data_byte_i};
  assign walk_en   = (off_q >= 12'd5) && !sel_q && (next_q < end_bound);
  assign rel       = off_q - base_q;
  assign cap_en    = sel_q && (off_q >= base_q) && (rel < 12'd8);
  assign tail      = {1'b0, base_q} + 13'd15;
  assign matched   = sel_q && ({1'b0, off_q} >= tail) && (ses_q == session_id_i);

  // parse state update
  always_comb begin
    off_d   = off_q;
    hlen_d  = hlen_q;
    next_d  = next_q;
    tkind_d = tkind_q;
    base_d  = base_q;
    sel_d   = sel_q;
    ses_d   = ses_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    if (is_byte) begin
      if (off_q == 12'd1) begin
        hlen_d = data_byte_i;
      end
      if (off_q == 12'd4) begin
        next_d = start[12] ? OffsetMax : start[11:0];
      end
      if (walk_en) begin
        if (off_q == next_q) begin
          tkind_d = data_byte_i;
        end else if ({1'b0, off_q} == next_p1) begin
          if (tkind_q == TlvTypeProbe && data_byte_i == TlvLenProbe) begin
            sel_d  = 1'b1;
            base_d = next_q;
          end else begin
            next_d = next_step[12] ? OffsetMax : next_step[11:0];
          end
        end
      end
      if (cap_en) begin
        unique case (rel[2:0])
          3'd2:    ses_d[15:8] = data_byte_i;
          3'd3:    ses_d[7:0]  = data_byte_i;
          3'd4:    seq_d[15:8] = data_byte_i;
          3'd5:    seq_d[7:0]  = data_byte_i;
          3'd6:    ack_d[15:8] = data_byte_i;
          3'd7:    ack_d[7:0]  = data_byte_i;
          default: ;
        endcase
      end
      if (off_q != OffsetMax) begin
        off_d = off_q + 12'd1;
      end
      // end of header clears everything for the next one
      if (last_byte_i) begin
        off_d   = '0;
        hlen_d  = '0;
        next_d  = '0;
        tkind_d = '0;
        base_d  = '0;
        sel_d   = 1'b0;
        ses_d   = '0;
        seq_d   = '0;
        ack_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      hlen_q  <= '0;
      next_q  <= '0;
      tkind_q <= '0;
      base_q  <= '0;
      sel_q   <= 1'b0;
      ses_q   <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
    end else begin
      off_q   <= off_d;
      hlen_q  <= hlen_d;
      next_q  <= next_d;
      tkind_q <= tkind_d;
      base_q  <= base_d;
      sel_q   <= sel_d;
      ses_q   <= ses_d;
      seq_q   <= seq_d;
      ack_q   <= ack_d;
    end
  end

  // event classification
  assign evt_push_o     = accept_i && (!is_byte || last_byte_i);
  assign evt_o.kind     = is_byte ? KindHeader : KindProbe;
  assign evt_o.matched  = is_byte && matched;
  assign evt_o.ack_zero = (ack_q == '0);
  assign evt_o.seq      = seq_q;

endmodule

### hw/rtl/slm_back.sv
// ---------------------------------------------------------------------------
// slm_back
// Link engine: keeps seq, ack and link state and builds one result per event.
// ---------------------------------------------------------------------------
module slm_back import slm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        evt_valid_i,
  input  slm_evt_t    evt_i,
  output logic        evt_pop_o,
  input  logic [15:0] loss_threshold_i,
  input  logic        res_full_i,
  output logic        res_push_o,
  output slm_res_t    res_o
);

  logic [15:0] sent_q, sent_d;
  logic [15:0] acked_q, acked_d;
  logic        link_q, link_d;
  logic        fire;
  logic        changed;
  logic [15:0] sent_inc;
  logic [15:0] unacked_gap;
  logic        in_window;

  assign fire       = evt_valid_i && !res_full_i;
  assign evt_pop_o  = fire;
  assign res_push_o = fire;

  assign sent_inc    = sent_q + 16'd1;
  assign unacked_gap = sent_inc - acked_q;
  assign in_window = ((sent_q > acked_q) && (evt_i.seq > acked_q) && (evt_i.seq <= sent_q)) ||
                     ((sent_q < acked_q) && ((evt_i.seq <= sent_q) || (evt_i.seq > acked_q)));

  // state update for one event
  always_comb begin
    sent_d  = sent_q;
    acked_d = acked_q;
    link_d  = link_q;
    changed = 1'b0;
    if (fire) begin
      unique case (evt_i.kind)
        KindProbe: begin
          if (link_q) begin
            sent_d = sent_inc;
            if (unacked_gap > loss_threshold_i) begin
              sent_d  = '0;
              acked_d = '0;
              link_d  = 1'b0;
              changed = 1'b1;
            end
          end
        end
        KindHeader: begin
          if (evt_i.matched) begin
            if (!link_q && evt_i.seq == '0 && evt_i.ack_zero) begin
              link_d  = 1'b1;
              changed = 1'b1;
            end else if (in_window) begin
              acked_d = evt_i.seq;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      acked_q <= '0;
      link_q  <= 1'b0;
    end else begin
      sent_q  <= sent_d;
      acked_q <= acked_d;
      link_q  <= link_d;
    end
  end

  // result fields after the update
  assign res_o.kind          = evt_i.kind;
  assign res_o.probe_seq     = link_d ? sent_d : '0;
  assign res_o.probe_ack     = link_d ? acked_d : '0;
  assign res_o.link_is_up    = link_d;
  assign res_o.link_changed  = changed;
  assign res_o.probe_matched = evt_i.matched;

  // seq and ack stay zero while the link is down
  a_down_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_q |-> (sent_q == '0 && acked_q == '0))
    else $error("seq or ack non-zero while link down");

  // a tick can only take the link down
  a_tick_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && evt_i.kind == KindProbe && changed) |=> !link_q)
    else $error("tick raised the link");

  // a header can only bring the link up
  a_hdr_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && evt_i.kind == KindHeader && changed) |=> link_q)
    else $error("header dropped the link");

  // while the link stays up, ack moves only after a matched header or a tick
  a_ack_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_q && $past(link_q) && acked_q != $past(acked_q)) |->
      ($past(fire) && $past(evt_i.matched))
      || ($past(fire) && $past(evt_i.kind) == KindProbe))
    else $error("ack changed without a matched header");

endmodule

### hw/rtl/seq_ack_liveness_monitor.sv
// ---------------------------------------------------------------------------
// seq_ack_liveness_monitor
// Link liveness monitor: header parser and link engine joined by an event
// queue, with a result queue towards the consumer.
// ---------------------------------------------------------------------------
// A result passes through the event queue and then the result queue before it is shown.
// Throughput: one transaction per cycle while the event queue is not full, set by the single-event link engine.
// Bytes that are not last produce no result but are held while the event queue is full.
// Reset: link down, seq and ack zero, parser cleared, session 1, threshold 3.
// ---------------------------------------------------------------------------
module seq_ack_liveness_monitor import slm_pkg::*; #(
  parameter int unsigned EvtDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue side
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic [15:0]        probe_seq_o,
  output logic [15:0]        probe_ack_o,
  output logic               link_is_up_o,
  output logic               link_changed_o,
  output logic               probe_matched_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic [15:0] session_id_q;
  logic [15:0] loss_threshold_q;
  logic        cfg_we;
  logic        accept;
  logic        evt_push, evt_full, evt_empty, evt_pop;
  slm_evt_t    evt_in, evt_out;
  logic        res_push, res_full;
  slm_res_t    res_in, res_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_id_q     <= SessionIdReset;
      loss_threshold_q <= LossThresholdReset;
    end else if (cfg_we) begin
      if (cfg_index_i == CfgSessionId) begin
        session_id_q <= cfg_wdata_i;
      end
      if (cfg_index_i == CfgLossThreshold) begin
        loss_threshold_q <= cfg_wdata_i;
      end
    end
  end

  // front: parse and classify
  assign full   = evt_full;
  assign accept = push && !evt_full;

  slm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .session_id_i (session_id_q),
    .evt_push_o   (evt_push),
    .evt_o        (evt_in)
  );

  // event queue between parser and engine
  slm_fifo #(
    .Width ($bits(slm_evt_t)),
    .Depth (EvtDepth)
  ) u_evt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .wdata_i (evt_in),
    .full_o  (evt_full),
    .pop_i   (evt_pop),
    .rdata_o (evt_out),
    .empty_o (evt_empty)
  );

  // back: link engine
  slm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_valid_i      (!evt_empty),
    .evt_i            (evt_out),
    .evt_pop_o        (evt_pop),
    .loss_threshold_i (loss_threshold_q),
    .res_full_i       (res_full),
    .res_push_o       (res_push),
    .res_o            (res_in)
  );

  // result queue towards the consumer
  slm_fifo #(
    .Width ($bits(slm_res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign kind_o          = res_out.kind;
  assign probe_seq_o     = res_out.probe_seq;
  assign probe_ack_o     = res_out.probe_ack;
  assign link_is_up_o    = res_out.link_is_up;
  assign link_changed_o  = res_out.link_changed;
  assign probe_matched_o = res_out.probe_matched;

endmodule
